// ===== hw/rtl/fqgs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqgs_pkg
// Shared types and constants of the frame quality gate and best-frame selector.
// ----------------------------------------------------------------------------
`default_nettype none

package fqgs_pkg;

  localparam int unsigned MetricW    = 16;
  localparam int unsigned SkipW      = 8;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned BestWaitDefault = 10;
  localparam logic [SkipW-1:0] SkipResetValue = 8'd10;

  typedef logic [MetricW-1:0] metric_t;

  typedef enum logic [2:0] {
    ST_UNPROCESSED  = 3'd0,
    ST_DEFOCUSED    = 3'd1,
    ST_INTERLACED   = 3'd2,
    ST_NO_IRIS      = 3'd3,
    ST_LOW_QUALITY  = 3'd4,
    ST_GOOD         = 3'd5,
    ST_GOT_TEMPLATE = 3'd6
  } status_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_FOCUS_THRESHOLD       = 3'd0,
    REG_INTERLACE_CHECK       = 3'd1,
    REG_CORRELATION_THRESHOLD = 3'd2,
    REG_MINIMUM_QUALITY       = 3'd3,
    REG_SKIP_AFTER_TEMPLATE   = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frame_quality_gate_selector.sv =====
// ----------------------------------------------------------------------------
// frame_quality_gate_selector
// Grades one frame's metrics per transaction against thresholds and tracks the
// best iris quality until a template is reported, then skips frames.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_ready    | focus_score, interlace_correlation,
//           |                        | iris_valid, iris_quality
//  output   | out_valid / out_ready  | frame_status, capture_frame, best_quality
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One transaction per cycle while the result channel is not stalled; the result appears in the cycle after acceptance.
//  Grading and counter updates sit between the input ports and the result
//  register, so the result register alone sets the latency.
//  in_ready is high while the result register is empty or being drained.
//  Reset clears all thresholds, counters and the held quality; the skip
//  length register resets to ten. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_quality_gate_selector #(
  parameter int unsigned BEST_WAIT = fqgs_pkg::BestWaitDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [15:0]                    focus_score,
  input  wire logic [15:0]                    interlace_correlation,
  input  wire logic                           iris_valid,
  input  wire logic [15:0]                    iris_quality,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          frame_status,
  output logic                                capture_frame,
  output logic [15:0]                         best_quality,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fqgs_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [fqgs_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int unsigned WaitW = (BEST_WAIT < 2) ? 1 : $clog2(BEST_WAIT + 1);
  localparam logic [WaitW-1:0] WaitLimit = WaitW'(BEST_WAIT);

  fqgs_pkg::metric_t               focus_threshold;
  logic                            interlace_check_enable;
  fqgs_pkg::metric_t               correlation_threshold;
  fqgs_pkg::metric_t               minimum_quality;
  logic [fqgs_pkg::SkipW-1:0]      skip_after_template;

  logic [fqgs_pkg::SkipW-1:0]      skip_left;
  logic [fqgs_pkg::SkipW-1:0]      skip_left_next;
  logic                            waiting_best;
  logic                            waiting_best_next;
  logic [WaitW-1:0]                wait_count;
  logic [WaitW-1:0]                wait_count_next;
  fqgs_pkg::metric_t               best_quality_held;
  fqgs_pkg::metric_t               best_quality_held_next;

  fqgs_pkg::status_t               grade;
  fqgs_pkg::status_t               status_next;
  logic                            capture_next;
  logic                            skipping;
  logic                            good;
  logic                            waiting_now;
  logic                            better;
  logic [WaitW-1:0]                wait_inc;
  logic                            done;
  logic                            accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_threshold        <= '0;
      interlace_check_enable <= 1'b0;
      correlation_threshold  <= '0;
      minimum_quality        <= '0;
      skip_after_template    <= fqgs_pkg::SkipResetValue;
    end else if (cfg_valid) begin
      case (cfg_index)
        fqgs_pkg::REG_FOCUS_THRESHOLD:       focus_threshold <= cfg_data;
        fqgs_pkg::REG_INTERLACE_CHECK:       interlace_check_enable <= cfg_data[0];
        fqgs_pkg::REG_CORRELATION_THRESHOLD: correlation_threshold <= cfg_data;
        fqgs_pkg::REG_MINIMUM_QUALITY:       minimum_quality <= cfg_data;
        fqgs_pkg::REG_SKIP_AFTER_TEMPLATE:   skip_after_template <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (focus_score < focus_threshold) begin
      grade = fqgs_pkg::ST_DEFOCUSED;
    end else if (interlace_check_enable && interlace_correlation < correlation_threshold) begin
      grade = fqgs_pkg::ST_INTERLACED;
    end else if (!iris_valid) begin
      grade = fqgs_pkg::ST_NO_IRIS;
    end else if (iris_quality < minimum_quality) begin
      grade = fqgs_pkg::ST_LOW_QUALITY;
    end else begin
      grade = fqgs_pkg::ST_GOOD;
    end
  end

  assign skipping    = skip_left != '0;
  assign good        = grade == fqgs_pkg::ST_GOOD;
  assign waiting_now = waiting_best || good;
  assign better      = good && (iris_quality > best_quality_held);
  assign wait_inc    = (better ? '0 : wait_count) + WaitW'(1);
  assign done        = waiting_now && (wait_inc == WaitLimit);

  always_comb begin
    skip_left_next         = skip_left;
    waiting_best_next      = waiting_best;
    wait_count_next        = wait_count;
    best_quality_held_next = best_quality_held;
    status_next            = grade;
    capture_next           = 1'b0;
    if (skipping) begin
      skip_left_next = skip_left - 8'd1;
      status_next    = fqgs_pkg::ST_UNPROCESSED;
    end else if (waiting_now) begin
      capture_next = better;
      if (done) begin
        status_next            = fqgs_pkg::ST_GOT_TEMPLATE;
        wait_count_next        = '0;
        waiting_best_next      = 1'b0;
        best_quality_held_next = '0;
        skip_left_next         = skip_after_template;
      end else begin
        wait_count_next        = wait_inc;
        waiting_best_next      = 1'b1;
        best_quality_held_next = better ? iris_quality : best_quality_held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left         <= '0;
      waiting_best      <= 1'b0;
      wait_count        <= '0;
      best_quality_held <= '0;
    end else if (accept) begin
      skip_left         <= skip_left_next;
      waiting_best      <= waiting_best_next;
      wait_count        <= wait_count_next;
      best_quality_held <= best_quality_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_status  <= status_next;
      capture_frame <= capture_next;
      best_quality  <= best_quality_held_next;
    end
  end

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction left no result");

  a_skip_no_capture: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == fqgs_pkg::ST_UNPROCESSED |-> !capture_frame)
    else $error("capture raised on a skipped frame");

  a_template_clears_best: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == fqgs_pkg::ST_GOT_TEMPLATE |-> best_quality == '0)
    else $error("held quality not cleared on template");

  a_capture_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && capture_frame |->
      (frame_status == fqgs_pkg::ST_GOOD || frame_status == fqgs_pkg::ST_GOT_TEMPLATE))
    else $error("capture on a frame that was not good");

  a_wait_bounded: assert property (@(posedge clk) disable iff (rst)
    wait_count < WaitLimit && (waiting_best || wait_count == '0))
    else $error("wait counter out of range");

endmodule

`default_nettype wire

// ===== bench/fqgs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqgs_checker
// Watches the frame, result and register channels of the frame quality gate,
// grades every accepted frame with its own copy of the thresholds and the
// best-frame state, and compares each result transaction with the oldest
// verdict still awaited.
// ----------------------------------------------------------------------------
module fqgs_checker #(
  parameter int unsigned BEST_WAIT = fqgs_pkg::BestWaitDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [15:0]                    focus_score,
  input  wire logic [15:0]                    interlace_correlation,
  input  wire logic                           iris_valid,
  input  wire logic [15:0]                    iris_quality,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [2:0]                     frame_status,
  input  wire logic                           capture_frame,
  input  wire logic [15:0]                    best_quality,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [fqgs_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [fqgs_pkg::CfgDataW-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  frames_checked,
  output int                                  templates_seen,
  output int                                  captures_seen,
  output int                                  skipped_seen
);

  typedef struct packed {
    fqgs_pkg::status_t status;
    logic              capture;
    fqgs_pkg::metric_t best;
  } verdict_t;

  verdict_t awaited_verdicts[$];

  fqgs_pkg::metric_t        thr_focus;
  logic                     interlace_on;
  fqgs_pkg::metric_t        thr_corr;
  fqgs_pkg::metric_t        thr_quality;
  logic [fqgs_pkg::SkipW-1:0] skip_len;

  logic [7:0]        frames_to_skip;
  logic              hunting;
  logic [7:0]        stale_frames;
  fqgs_pkg::metric_t best_held;

  initial begin
    fail_count     = 0;
    pending        = 0;
    frames_checked = 0;
    templates_seen = 0;
    captures_seen  = 0;
    skipped_seen   = 0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got_v, want_v);
    fail_count++;
  endtask

  function automatic fqgs_pkg::status_t grade_metrics(input fqgs_pkg::metric_t focus,
                                                      input fqgs_pkg::metric_t corr,
                                                      input logic valid,
                                                      input fqgs_pkg::metric_t qual);
    if (focus < thr_focus) return fqgs_pkg::ST_DEFOCUSED;
    if (interlace_on && corr < thr_corr) return fqgs_pkg::ST_INTERLACED;
    if (!valid) return fqgs_pkg::ST_NO_IRIS;
    if (qual < thr_quality) return fqgs_pkg::ST_LOW_QUALITY;
    return fqgs_pkg::ST_GOOD;
  endfunction

  task automatic judge_frame(input fqgs_pkg::metric_t focus, input fqgs_pkg::metric_t corr,
                             input logic valid, input fqgs_pkg::metric_t qual,
                             output verdict_t v);
    fqgs_pkg::status_t st;
    logic cap;
    cap = 1'b0;
    if (frames_to_skip != 8'd0) begin
      frames_to_skip = frames_to_skip - 8'd1;
      v.status  = fqgs_pkg::ST_UNPROCESSED;
      v.capture = 1'b0;
      v.best    = best_held;
      return;
    end
    st = grade_metrics(focus, corr, valid, qual);
    if (st == fqgs_pkg::ST_GOOD) hunting = 1'b1;
    if (hunting) begin
      if (st == fqgs_pkg::ST_GOOD && qual > best_held) begin
        best_held    = qual;
        stale_frames = 8'd0;
        cap          = 1'b1;
      end
      stale_frames = stale_frames + 8'd1;
      if (stale_frames == 8'(BEST_WAIT)) begin
        st             = fqgs_pkg::ST_GOT_TEMPLATE;
        stale_frames   = 8'd0;
        hunting        = 1'b0;
        best_held      = '0;
        frames_to_skip = skip_len;
      end
    end
    v.status  = st;
    v.capture = cap;
    v.best    = best_held;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      thr_focus      = '0;
      interlace_on   = 1'b0;
      thr_corr       = '0;
      thr_quality    = '0;
      skip_len       = fqgs_pkg::SkipResetValue;
      frames_to_skip = '0;
      hunting        = 1'b0;
      stale_frames   = '0;
      best_held      = '0;
      awaited_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_verdicts.size() == 0) begin
          report_mismatch("result with no frame awaiting it", int'(frame_status), 0);
        end else begin
          want = awaited_verdicts.pop_front();
          frames_checked++;
          if (frame_status !== want.status)
            report_mismatch("frame_status", int'(frame_status), int'(want.status));
          if (capture_frame !== want.capture)
            report_mismatch("capture_frame", int'(capture_frame), int'(want.capture));
          if (best_quality !== want.best)
            report_mismatch("best_quality", int'(best_quality), int'(want.best));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (fqgs_pkg::cfg_reg_t'(cfg_index))
          fqgs_pkg::REG_FOCUS_THRESHOLD:       thr_focus    = cfg_data;
          fqgs_pkg::REG_INTERLACE_CHECK:       interlace_on = cfg_data[0];
          fqgs_pkg::REG_CORRELATION_THRESHOLD: thr_corr     = cfg_data;
          fqgs_pkg::REG_MINIMUM_QUALITY:       thr_quality  = cfg_data;
          fqgs_pkg::REG_SKIP_AFTER_TEMPLATE:   skip_len     = cfg_data[fqgs_pkg::SkipW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        judge_frame(focus_score, interlace_correlation, iris_valid, iris_quality, want);
        if (want.status == fqgs_pkg::ST_GOT_TEMPLATE) templates_seen++;
        if (want.status == fqgs_pkg::ST_UNPROCESSED) skipped_seen++;
        if (want.capture) captures_seen++;
        awaited_verdicts.push_back(want);
      end
    end
    pending = awaited_verdicts.size();
  end

endmodule

// ===== bench/tb_frame_quality_gate_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_quality_gate_selector
// Drives frames and register writes into the frame quality gate, stalls the
// result channel at random and once for a long stretch, and gives the verdict
// from the failure and pending counts of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_frame_quality_gate_selector;

  localparam int IdleLimit    = 2000;
  localparam int PhaseCount   = 8;
  localparam int PhaseFrames  = 119;
  localparam int HoldCycles   = 64;
  localparam int SettleCycles = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] focus_score = '0;
  logic [15:0] interlace_correlation = '0;
  logic        iris_valid = 1'b0;
  logic [15:0] iris_quality = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  frame_status;
  logic        capture_frame;
  logic [15:0] best_quality;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [fqgs_pkg::CfgIndexW-1:0] cfg_index = fqgs_pkg::REG_FOCUS_THRESHOLD;
  logic [fqgs_pkg::CfgDataW-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int frames_checked;
  int templates_seen;
  int captures_seen;
  int skipped_seen;

  logic    in_took = 1'b0;
  logic    cfg_took = 1'b0;
  int      quiet_cycles = 0;
  int      idle_pct = 27;
  int      hold_wanted = 0;
  int      holds_done = 0;
  int      settings_used = 0;

  fqgs_pkg::metric_t gate_focus = '0;
  fqgs_pkg::metric_t gate_corr = '0;
  fqgs_pkg::metric_t gate_quality = '0;

  frame_quality_gate_selector u_top (.*);
  fqgs_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    in_took  <= in_valid && in_ready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(negedge clk) begin
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (holds_done < hold_wanted) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        holds_done++;
      end
      out_ready = ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_frame(input fqgs_pkg::metric_t focus, input fqgs_pkg::metric_t corr,
                            input logic valid, input fqgs_pkg::metric_t qual);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    focus_score           = focus;
    interlace_correlation = corr;
    iris_valid            = valid;
    iris_quality          = qual;
    in_valid              = 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic write_reg(input fqgs_pkg::cfg_reg_t idx,
                           input logic [fqgs_pkg::CfgDataW-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic apply_settings(input fqgs_pkg::metric_t focus, input logic interlace,
                                input fqgs_pkg::metric_t corr, input fqgs_pkg::metric_t qual,
                                input logic [7:0] skip);
    gate_focus   = focus;
    gate_corr    = corr;
    gate_quality = qual;
    write_reg(fqgs_pkg::REG_FOCUS_THRESHOLD, focus);
    write_reg(fqgs_pkg::REG_INTERLACE_CHECK, {15'd0, interlace});
    write_reg(fqgs_pkg::REG_CORRELATION_THRESHOLD, corr);
    write_reg(fqgs_pkg::REG_MINIMUM_QUALITY, qual);
    write_reg(fqgs_pkg::REG_SKIP_AFTER_TEMPLATE, {8'd0, skip});
    settings_used++;
  endtask

  function automatic fqgs_pkg::metric_t near_threshold(input fqgs_pkg::metric_t thr);
    case ($urandom_range(7))
      0: return (thr == 16'd0) ? 16'd0 : thr - 16'd1;
      1: return thr;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return 16'($urandom_range(32'hFFFF, 32'(thr)));
    endcase
  endfunction

  task automatic offer_random_frame();
    if ($urandom_range(99) < 15)
      send_frame(16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
    else
      send_frame(near_threshold(gate_focus), near_threshold(gate_corr),
                 $urandom_range(99) < 90, near_threshold(gate_quality));
  endtask

  function automatic fqgs_pkg::metric_t random_threshold();
    return 16'($urandom_range(32'hC000));
  endfunction

  initial begin
    logic [7:0] skip;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_frame(16'h0000, 16'h0000, 1'b1, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
    send_frame(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
    wait_drained();

    apply_settings(16'h1000, 1'b1, 16'h0800, 16'h0100, 8'd2);
    send_frame(16'h0FFF, 16'hFFFF, 1'b1, 16'hFFFF);
    send_frame(16'h1000, 16'h07FF, 1'b1, 16'hFFFF);
    send_frame(16'h1000, 16'h0800, 1'b0, 16'hFFFF);
    send_frame(16'hFFFF, 16'h0800, 1'b1, 16'h00FF);
    send_frame(16'hFFFF, 16'hFFFF, 1'b1, 16'h0100);
    for (int k = 0; k < 16; k++) begin
      send_frame(16'h1000, 16'h0800, 1'b1, 16'h0100);
    end
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 0) begin
        apply_settings(16'h0000, 1'b0, 16'h0000, 16'h0000, 8'd0);
      end else if (p == PhaseCount - 1) begin
        apply_settings(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'd255);
      end else begin
        skip = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        apply_settings(random_threshold(), 1'($urandom), random_threshold(),
                       random_threshold(), skip);
      end
      idle_pct = (p == 2) ? 0 : 27;
      if (p == 3) hold_wanted++;
      for (int n = 0; n < PhaseFrames; n++) begin
        offer_random_frame();
      end
      wait_drained();
    end

    idle_pct = 27;
    repeat (SettleCycles) @(negedge clk);
    $display("Checked %0d frames under %0d threshold settings, with one long result stall.",
             frames_checked, settings_used);
    $display("Saw %0d templates, %0d captures and %0d skipped frames; %0d mismatches.",
             templates_seen, captures_seen, skipped_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fqgs_pkg.sv
hw/rtl/frame_quality_gate_selector.sv
bench/fqgs_checker.sv
bench/tb_frame_quality_gate_selector.sv
